/* rtl/aabb_pkg.sv */
// ----------------------------------------------------------------------------
// AABB affine transform package
// Shared payload types and fixed constants of the box transform block.
// ----------------------------------------------------------------------------
package aabb_pkg;

	localparam int unsigned FieldBits = 32;
	localparam int unsigned Rows      = 3;
	localparam int unsigned Corners   = 8;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_BOX  = 1'b1
	} req_type_t;

	typedef struct packed {
		logic               req_type;
		logic [1:0]         row_sel;
		logic signed [31:0] coef_a;
		logic signed [31:0] coef_b;
		logic signed [31:0] coef_c;
		logic signed [31:0] coef_t;
		logic signed [31:0] box_lo_x;
		logic signed [31:0] box_lo_y;
		logic signed [31:0] box_lo_z;
		logic signed [31:0] box_hi_x;
		logic signed [31:0] box_hi_y;
		logic signed [31:0] box_hi_z;
	} req_t;

	typedef struct packed {
		logic signed [31:0] out_lo_x;
		logic signed [31:0] out_lo_y;
		logic signed [31:0] out_lo_z;
		logic signed [31:0] out_hi_x;
		logic signed [31:0] out_hi_y;
		logic signed [31:0] out_hi_z;
		logic               sat_flag;
	} rsp_t;

	// One queued box job: the two corners.
	typedef struct packed {
		logic signed [31:0] lo_x;
		logic signed [31:0] lo_y;
		logic signed [31:0] lo_z;
		logic signed [31:0] hi_x;
		logic signed [31:0] hi_y;
		logic signed [31:0] hi_z;
	} box_t;

endpackage

/* rtl/aabb_if.sv */
// ----------------------------------------------------------------------------
// AABB stream interfaces
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface aabb_req_if;
	logic          valid;
	logic          ready;
	aabb_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface aabb_rsp_if;
	logic          valid;
	logic          ready;
	aabb_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* rtl/aabb_front.sv */
// ----------------------------------------------------------------------------
// AABB front end
// Accepts requests, applies row loads to the matrix, queues boxes.
// ----------------------------------------------------------------------------
module aabb_front #(
	parameter int unsigned FRAC_BITS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	aabb_req_if.sink            req,
	output logic                box_valid,
	input  logic                box_ready,
	output aabb_pkg::box_t      box,
	input  logic                mat_busy,
	output logic signed [31:0]  mat_q [12]
);

	localparam logic signed [31:0] One = 32'(64'(1) << FRAC_BITS);

	// Two-entry queue decouples intake from the corner engine.
	aabb_pkg::box_t fifo_q [2];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     count_q;
	logic           acc, push, pop, load;

	// A row load must wait until boxes ahead of it have finished with the matrix.
	assign req.ready = (req.data.req_type == aabb_pkg::REQ_BOX) ? (count_q != 2'd2)
		: (count_q == 2'd0 && !mat_busy);
	assign acc  = req.valid && req.ready;
	assign push = acc && req.data.req_type == aabb_pkg::REQ_BOX;
	assign load = acc && req.data.req_type == aabb_pkg::REQ_LOAD && req.data.row_sel != 2'd3;
	assign pop  = box_valid && box_ready;
	assign box_valid = count_q != 2'd0;
	assign box = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
			for (int i = 0; i < 12; i++) mat_q[i] <= (i % 5 == 0) ? One : '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
			if (load) begin
				mat_q[{req.data.row_sel, 2'd0}] <= req.data.coef_a;
				mat_q[{req.data.row_sel, 2'd1}] <= req.data.coef_b;
				mat_q[{req.data.row_sel, 2'd2}] <= req.data.coef_c;
				mat_q[{req.data.row_sel, 2'd3}] <= req.data.coef_t;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= '{req.data.box_lo_x, req.data.box_lo_y,
			req.data.box_lo_z, req.data.box_hi_x, req.data.box_hi_y, req.data.box_hi_z};
	end

endmodule

/* rtl/aabb_back.sv */
// ----------------------------------------------------------------------------
// AABB corner engine
// One corner per cycle when not stalled: nine multipliers, then a min/max fold.
// ----------------------------------------------------------------------------
module aabb_back #(
	parameter int unsigned COORD_BITS = 32,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                box_valid,
	output logic                box_ready,
	input  aabb_pkg::box_t      box,
	input  logic signed [31:0]  mat_q [12],
	output logic                mat_busy,
	aabb_rsp_if.source          rsp
);

	localparam logic signed [65:0] CMax = (COORD_BITS >= 64) ? 66'sh0_7FFF_FFFF_FFFF_FFFF
		: 66'((67'sd1 <<< (COORD_BITS - 1)) - 1);
	localparam logic signed [65:0] CMin = -CMax - 66'sd1;
	localparam logic signed [65:0] I64Max = 66'sh0_7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [65:0] I64Min = -I64Max - 66'sd1;

	// Stage 0: corner counter over the current box.
	logic           busy_q;
	logic [2:0]     k_q;
	aabb_pkg::box_t cur_q;
	logic           adv;
	// Stage 1 products, stage 2 sums, stage 3 fold.
	logic               v_s1, last_s1, v_s2, last_s2, first_s2;
	logic               first_s1;
	logic signed [63:0] p_s1 [3][3];
	logic signed [31:0] t_s1 [3];
	logic signed [63:0] c_s2 [3];
	logic               sat_s2;
	logic signed [63:0] mn_q [3], mx_q [3];
	logic               satacc_q, out_v_q;

	// Stall the whole engine while a finished result has not been taken.
	assign adv = !(out_v_q && !rsp.ready);
	assign box_ready = adv && (!busy_q || k_q == 3'd7);
	assign mat_busy = busy_q || v_s1 || v_s2;

	logic signed [31:0] cx, cy, cz;
	assign cx = k_q[2] ? cur_q.hi_x : cur_q.lo_x;
	assign cy = k_q[1] ? cur_q.hi_y : cur_q.lo_y;
	assign cz = k_q[0] ? cur_q.hi_z : cur_q.lo_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; k_q <= '0;
			v_s1 <= 1'b0; v_s2 <= 1'b0; out_v_q <= 1'b0;
		end else begin
			if (adv && v_s2 && last_s2) out_v_q <= 1'b1;
			else if (rsp.valid && rsp.ready) out_v_q <= 1'b0;
			if (adv) begin
				v_s1 <= busy_q;
				v_s2 <= v_s1;
				if (box_valid && box_ready) begin
					busy_q <= 1'b1; k_q <= '0;
				end else if (busy_q) begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd7) busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (box_valid && box_ready) cur_q <= box;
			first_s1 <= k_q == 3'd0;
			last_s1  <= k_q == 3'd7;
			for (int r = 0; r < 3; r++) begin
				p_s1[r][0] <= 64'(mat_q[4*r])   * 64'(cx);
				p_s1[r][1] <= 64'(mat_q[4*r+1]) * 64'(cy);
				p_s1[r][2] <= 64'(mat_q[4*r+2]) * 64'(cz);
				t_s1[r]    <= mat_q[4*r+3];
			end
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			begin
				logic signed [65:0] s;
				logic               sf;
				sf = 1'b0;
				for (int r = 0; r < 3; r++) begin
					// Each partial sum saturates to 64 bits before the next term is added.
					s = 66'(p_s1[r][0] >>> FRAC_BITS) + 66'(p_s1[r][1] >>> FRAC_BITS);
					if (s > I64Max) begin s = I64Max; sf = 1'b1; end
					if (s < I64Min) begin s = I64Min; sf = 1'b1; end
					s = s + 66'(p_s1[r][2] >>> FRAC_BITS);
					if (s > I64Max) begin s = I64Max; sf = 1'b1; end
					if (s < I64Min) begin s = I64Min; sf = 1'b1; end
					s = s + 66'(t_s1[r]);
					if (s > I64Max) begin s = I64Max; sf = 1'b1; end
					if (s < I64Min) begin s = I64Min; sf = 1'b1; end
					if (s > CMax) begin s = CMax; sf = 1'b1; end
					if (s < CMin) begin s = CMin; sf = 1'b1; end
					c_s2[r] <= s[63:0];
				end
				sat_s2 <= sf;
			end
			if (v_s2) begin
				for (int r = 0; r < 3; r++) begin
					if (first_s2 || c_s2[r] < mn_q[r]) mn_q[r] <= c_s2[r];
					if (first_s2 || c_s2[r] > mx_q[r]) mx_q[r] <= c_s2[r];
				end
				satacc_q <= (first_s2 ? 1'b0 : satacc_q) | sat_s2;
			end
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.data = '{mn_q[0][31:0], mn_q[1][31:0], mn_q[2][31:0],
		mx_q[0][31:0], mx_q[1][31:0], mx_q[2][31:0], satacc_q};

endmodule

/* rtl/aabb_affine_transform.sv */
// ----------------------------------------------------------------------------
// AABB affine transform
// Transforms an axis-aligned box through a loaded 3x4 Q16.16 matrix.
// ----------------------------------------------------------------------------
// The corner engine takes the eight corners of a box one per cycle, unless it is
// stalled by a result that has not been taken, through nine 32x32 multipliers;
// each corner passes the product, sum and fold registers before the result appears.
// Boxes stream back to back through a two-entry queue; a row load waits until
// every earlier box has left the engine. The matrix resets to identity. Load
// items return no result.
module aabb_affine_transform #(
	parameter int unsigned COORD_BITS = 32,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	aabb_req_if.sink   req,
	aabb_rsp_if.source rsp
);

	logic               box_valid, box_ready, mat_busy;
	aabb_pkg::box_t     box;
	logic signed [31:0] mat_q [12];

	aabb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n, .req, .box_valid, .box_ready, .box, .mat_busy, .mat_q
	);

	aabb_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .box_valid, .box_ready, .box, .mat_q, .mat_busy, .rsp
	);

endmodule
